// ===== rtl/hkct_pkg.sv =====
// ----------------------------------------------------------------------------
// hkct_pkg
// types and constants shared by the keyed counter table modules
// ----------------------------------------------------------------------------
package hkct_pkg;

  localparam int COUNT_W = 32;
  localparam int KEY_W   = 32;
  localparam int BCNT_W  = 9;
  localparam int STAT_W  = 2;

  localparam logic OPC_INC  = 1'b0;
  localparam logic OPC_READ = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [STAT_W-1:0]  status;
  } out_item_t;

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    bump = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage

// ===== rtl/hkct_ram.sv =====
// ----------------------------------------------------------------------------
// hkct_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
module hkct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== rtl/hkct_div.sv =====
// ----------------------------------------------------------------------------
// hkct_div
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module hkct_div
  import hkct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  dividend,
  input  logic [BCNT_W-1:0] divisor,
  output logic              done_r,
  output logic [BCNT_W-1:0] rem_r
);

  localparam int CW = $clog2(KEY_W + 1);

  logic [KEY_W-1:0]  dvd_r;
  logic [BCNT_W-1:0] dsr_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic [BCNT_W:0]   trial;
  logic [BCNT_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[KEY_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = BCNT_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[BCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[KEY_W-2:0], 1'b0};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(KEY_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/hashed_key_counter_table.sv =====
// ----------------------------------------------------------------------------
// hashed_key_counter_table
// keyed counter table: probed home slots in one ram, overflow pool in another
// ----------------------------------------------------------------------------
// each item: key mod bucket count in the remainder unit, then slot probes at
//   home plus offset 0, 1, 2, 4 and so on (at most ceil(log2(bucket count))+1
//   probes), then a scan of the pool entries when the probes run out; the
//   result item is presented from a register
// one item at a time: no new item is taken until the result item has left
// reset and every bucket count write run a clearing pass over
//   max(TABLE_DEPTH, OVERFLOW_DEPTH) entries with no item taken
module hashed_key_counter_table
  import hkct_pkg::*;
#(
  parameter int TABLE_DEPTH    = 256,
  parameter int OVERFLOW_DEPTH = 16,
  parameter int KEY_WIDTH      = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BCNT_W-1:0] cfg_data
);

  localparam int KW   = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam int TAW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SAW  = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
  localparam int CLRN = (TABLE_DEPTH > OVERFLOW_DEPTH) ? TABLE_DEPTH : OVERFLOW_DEPTH;
  localparam int CLW  = $clog2(CLRN + 1);
  localparam int EW   = 1 + KW + COUNT_W;
  localparam int OFFW = BCNT_W + 1;
  localparam logic [BCNT_W-1:0] BCNT_RST = BCNT_W'((TABLE_DEPTH < 256) ? TABLE_DEPTH : 256);
  localparam logic [SAW-1:0]    SP_LAST  = SAW'(OVERFLOW_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DIV, S_PRB, S_PCHK, S_SRD, S_SCHK, S_OUT
  } state_t;

  typedef struct packed {
    logic               used;
    logic [KW-1:0]      key;
    logic [COUNT_W-1:0] count;
  } entry_t;

  state_t            state_r;
  logic [CLW-1:0]    clr_r;
  logic [BCNT_W-1:0] bcnt_r;
  logic              rd_r;
  logic [KW-1:0]     key_r;
  logic [BCNT_W-1:0] home_r;
  logic [OFFW-1:0]   off_r;
  logic [SAW-1:0]    sp_r;
  logic              free_r;
  logic [SAW-1:0]    free_idx_r;
  out_item_t         out_r;

  logic              div_start;
  logic              div_done;
  logic [BCNT_W-1:0] div_rem;

  logic [OFFW:0]     sum;
  logic [OFFW:0]     slot_s;
  logic [BCNT_W-1:0] cfg_v;

  logic           t_we, p_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [SAW-1:0] p_waddr, p_raddr;
  entry_t         t_wdata, p_wdata, t_rdata, p_rdata;
  logic [EW-1:0]  t_rbits, p_rbits;

  assign t_rdata = entry_t'(t_rbits);
  assign p_rdata = entry_t'(p_rbits);

  // the divider loads its dividend at the accepting edge, straight from the item
  hkct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (KEY_W'(in_data.key[KW-1:0])),
    .divisor  (bcnt_r),
    .done_r   (div_done),
    .rem_r    (div_rem)
  );

  hkct_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_slot_ram (
    .clk     (clk),
    .we      (t_we),
    .waddr   (t_waddr),
    .wdata   (t_wdata),
    .raddr   (t_raddr),
    .rdata_r (t_rbits)
  );

  hkct_ram #(.WIDTH(EW), .DEPTH(OVERFLOW_DEPTH)) u_pool_ram (
    .clk     (clk),
    .we      (p_we),
    .waddr   (p_waddr),
    .wdata   (p_wdata),
    .raddr   (p_raddr),
    .rdata_r (p_rbits)
  );

  // probe slot, home + off wraps at most once since both are below bucket count
  always_comb begin
    sum = (OFFW + 1)'(home_r) + (OFFW + 1)'(off_r);
    if (sum >= (OFFW + 1)'(bcnt_r)) begin
      slot_s = sum - (OFFW + 1)'(bcnt_r);
    end else begin
      slot_s = sum;
    end
  end

  always_comb begin
    cfg_v = cfg_data;
    if (cfg_v == '0) begin
      cfg_v = BCNT_W'(1);
    end
    if (32'(cfg_v) > 32'(TABLE_DEPTH)) begin
      cfg_v = BCNT_W'(TABLE_DEPTH);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;
  assign div_start = (state_r == S_IDLE) && in_valid;
  assign t_raddr   = TAW'(slot_s);
  assign p_raddr   = sp_r;

  always_comb begin
    t_we    = 1'b0;
    t_waddr = TAW'(slot_s);
    t_wdata = '0;
    p_we    = 1'b0;
    p_waddr = sp_r;
    p_wdata = '0;
    if (state_r == S_CLR) begin
      t_we    = 1'b1;
      t_waddr = TAW'(clr_r);
      p_we    = 1'b1;
      p_waddr = SAW'(clr_r);
    end else if (state_r == S_PCHK && !rd_r) begin
      if (!t_rdata.used) begin
        t_we    = 1'b1;
        t_wdata = '{used: 1'b1, key: key_r, count: COUNT_W'(1)};
      end else if (t_rdata.key == key_r) begin
        t_we    = 1'b1;
        t_wdata = '{used: 1'b1, key: key_r, count: bump(t_rdata.count)};
      end
    end else if (state_r == S_SCHK && !rd_r) begin
      if (p_rdata.used && p_rdata.key == key_r) begin
        p_we    = 1'b1;
        p_wdata = '{used: 1'b1, key: key_r, count: bump(p_rdata.count)};
      end else if (sp_r == SP_LAST && (free_r || !p_rdata.used)) begin
        p_we    = 1'b1;
        p_waddr = free_r ? free_idx_r : sp_r;
        p_wdata = '{used: 1'b1, key: key_r, count: COUNT_W'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      bcnt_r  <= BCNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      bcnt_r  <= cfg_v;
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + CLW'(1);
          if (clr_r == CLW'(CLRN - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            rd_r    <= (in_data.opcode == OPC_READ);
            key_r   <= in_data.key[KW-1:0];
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            home_r  <= div_rem;
            off_r   <= '0;
            state_r <= S_PRB;
          end
        end
        S_PRB: begin
          if (off_r >= OFFW'(bcnt_r)) begin
            sp_r    <= '0;
            free_r  <= 1'b0;
            state_r <= S_SRD;
          end else begin
            state_r <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (!t_rdata.used) begin
            out_r   <= rd_r ? '{count: '0, status: ST_NOT_FOUND}
                            : '{count: COUNT_W'(1), status: ST_OK};
            state_r <= S_OUT;
          end else if (t_rdata.key == key_r) begin
            out_r   <= '{count: rd_r ? t_rdata.count : bump(t_rdata.count), status: ST_OK};
            state_r <= S_OUT;
          end else begin
            off_r   <= (off_r == '0) ? OFFW'(1) : {off_r[OFFW-2:0], 1'b0};
            state_r <= S_PRB;
          end
        end
        S_SRD: begin
          state_r <= S_SCHK;
        end
        S_SCHK: begin
          if (p_rdata.used && p_rdata.key == key_r) begin
            out_r   <= '{count: rd_r ? p_rdata.count : bump(p_rdata.count), status: ST_OK};
            state_r <= S_OUT;
          end else if (sp_r == SP_LAST) begin
            if (rd_r) begin
              out_r <= '{count: '0, status: ST_NOT_FOUND};
            end else if (free_r || !p_rdata.used) begin
              out_r <= '{count: COUNT_W'(1), status: ST_OK};
            end else begin
              out_r <= '{count: '0, status: ST_FULL};
            end
            state_r <= S_OUT;
          end else begin
            // remember the lowest free pool entry
            if (!p_rdata.used && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= sp_r;
            end
            sp_r    <= sp_r + SAW'(1);
            state_r <= S_SRD;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/hkct_checker.sv =====
// ----------------------------------------------------------------------------
// hkct_checker
// port level checks on the keyed counter table
// ----------------------------------------------------------------------------
module hkct_checker
  import hkct_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input in_item_t          in_data,
  input logic              out_valid,
  input logic              out_stall,
  input out_item_t         out_data,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [BCNT_W-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NOT_FOUND || out_data.status == ST_FULL)
      |-> out_data.count == '0)
    else $error("miss or full result with nonzero count");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");

endmodule

bind hashed_key_counter_table hkct_checker u_hkct_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives increments and reads into the keyed counter table, predicts counts
// and status with a behavioural table, and checks every result item in order
// ----------------------------------------------------------------------------
module tb_top;
  import hkct_pkg::*;

  localparam int DEPTH = 256;
  localparam int POOL  = 16;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [BCNT_W-1:0] cfg_data = '0;

  hashed_key_counter_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioural copy of the table
  int unsigned       buckets;
  bit                slot_full [DEPTH];
  logic [KEY_W-1:0]  slot_k [DEPTH];
  logic [COUNT_W-1:0] slot_n [DEPTH];
  bit                pool_full [POOL];
  logic [KEY_W-1:0]  pool_k [POOL];
  logic [COUNT_W-1:0] pool_n [POOL];

  out_item_t expected_q[$];
  int        errors = 0;
  bit        quiet = 1'b0;
  logic [KEY_W-1:0] key_set[8];

  function automatic void clear_table(input int unsigned bc);
    buckets = bc;
    foreach (slot_full[i]) slot_full[i] = 1'b0;
    foreach (pool_full[i]) pool_full[i] = 1'b0;
  endfunction

  function automatic logic [COUNT_W-1:0] incr(input logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + COUNT_W'(1);
  endfunction

  function automatic out_item_t predict_count(input in_item_t it);
    out_item_t r;
    int unsigned home, off, s;
    bit rd;
    rd = (it.opcode == OPC_READ);
    home = it.key % buckets;
    off = 0;
    while (off < buckets) begin
      s = (home + off) % buckets;
      if (!slot_full[s]) begin
        if (rd) begin
          r.count = '0; r.status = ST_NOT_FOUND;
        end else begin
          slot_full[s] = 1'b1; slot_k[s] = it.key; slot_n[s] = COUNT_W'(1);
          r.count = COUNT_W'(1); r.status = ST_OK;
        end
        return r;
      end
      if (slot_k[s] == it.key) begin
        if (!rd) slot_n[s] = incr(slot_n[s]);
        r.count = slot_n[s]; r.status = ST_OK;
        return r;
      end
      off = (off == 0) ? 1 : off * 2;
    end
    for (int i = 0; i < POOL; i++) begin
      if (pool_full[i] && pool_k[i] == it.key) begin
        if (!rd) pool_n[i] = incr(pool_n[i]);
        r.count = pool_n[i]; r.status = ST_OK;
        return r;
      end
    end
    r.count = '0;
    if (rd) begin
      r.status = ST_NOT_FOUND;
      return r;
    end
    for (int i = 0; i < POOL; i++) begin
      if (!pool_full[i]) begin
        pool_full[i] = 1'b1; pool_k[i] = it.key; pool_n[i] = COUNT_W'(1);
        r.count = COUNT_W'(1); r.status = ST_OK;
        return r;
      end
    end
    r.status = ST_FULL;
    return r;
  endfunction

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // send one item; typed expectation used when check_typed is set
  task automatic send_item(input in_item_t it, input bit check_typed,
                           input out_item_t typed);
    out_item_t p;
    idle_gap();
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    p = predict_count(it);
    if (check_typed && p != typed) begin
      $error("typed row disagrees with predictor: %h vs %h", typed, p);
      errors++;
    end
    expected_q.push_back(check_typed ? typed : p);
  endtask

  task automatic write_buckets(input logic [BCNT_W-1:0] v);
    int unsigned bc;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bc = (v == 0) ? 1 : ((v > DEPTH) ? DEPTH : v);
    clear_table(bc);
  endtask

  // output side: random stall bursts, compare with oldest expectation
  initial begin
    out_item_t e;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: %h", out_data);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.count !== e.count) begin
            $error("count: expected %h actual %h", e.count, out_data.count);
            errors++;
          end
          if (out_data.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_data.status);
            errors++;
          end
        end
      end
      if (!quiet && out_stall == 1'b0 && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  typedef struct {
    logic             opc;
    logic [KEY_W-1:0] key;
    bit               typed;
    logic [COUNT_W-1:0] cnt;
    logic [STAT_W-1:0]  st;
  } row_t;

  row_t rows[] = '{
    '{OPC_READ, 32'h0,        1, 32'd0, ST_NOT_FOUND},
    '{OPC_INC,  32'h0,        1, 32'd1, ST_OK},
    '{OPC_INC,  32'h0,        1, 32'd2, ST_OK},
    '{OPC_READ, 32'h0,        1, 32'd2, ST_OK},
    '{OPC_INC,  32'hFFFFFFFF, 1, 32'd1, ST_OK},
    '{OPC_READ, 32'hFFFFFFFF, 1, 32'd1, ST_OK},
    '{OPC_INC,  32'h100,      0, 32'd0, ST_OK},
    '{OPC_INC,  32'h200,      0, 32'd0, ST_OK},
    '{OPC_READ, 32'h100,      0, 32'd0, ST_OK},
    '{OPC_READ, 32'hAAAA5555, 1, 32'd0, ST_NOT_FOUND}
  };

  initial begin
    in_item_t  it;
    out_item_t t;
    clear_table(DEPTH);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) begin
      it.opcode = rows[i].opc; it.key = rows[i].key;
      t.count = rows[i].cnt; t.status = rows[i].st;
      send_item(it, rows[i].typed, t);
    end
    // one bucket: everything beyond one key spills, pool fills then reports full
    write_buckets(9'd1);
    for (int i = 0; i < POOL + 3; i++) begin
      it.opcode = OPC_INC; it.key = 32'(i * 7 + 3);
      t.count = (i < POOL + 1) ? COUNT_W'(1) : '0;
      t.status = (i < POOL + 1) ? ST_OK : ST_FULL;
      send_item(it, 1'b1, t);
    end
    it.opcode = OPC_READ; it.key = 32'hDEAD;
    t.count = '0; t.status = ST_NOT_FOUND;
    send_item(it, 1'b1, t);
    // zero acts as one, values past the depth act as the depth
    write_buckets(9'd0);
    write_buckets(9'd511);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: write_buckets(9'd256);
        1: write_buckets(9'd2);
        2: write_buckets(9'(($urandom_range(3, 40))));
        default: write_buckets(9'(($urandom_range(1, 511))));
      endcase
      foreach (key_set[k]) key_set[k] = $urandom();
      if (ph == 7) quiet = 1'b1;
      for (int n = 0; n < 100; n++) begin
        it.opcode = ($urandom_range(0, 2) == 0) ? OPC_READ : OPC_INC;
        it.key = ($urandom_range(0, 3) == 0) ? $urandom()
                                             : key_set[$urandom_range(0, 7)];
        send_item(it, 1'b0, t);
      end
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hkct_pkg.sv
rtl/hkct_ram.sv
rtl/hkct_div.sv
rtl/hashed_key_counter_table.sv
rtl/hkct_checker.sv
test/tb_top.sv
